// ===== hdl/lcw_pkg.sv =====
// shared types and constants for the format80 decompressor
package lcw_pkg;

  localparam int OUT_SIZE = 65536;
  localparam int POS_W    = 17;
  localparam int HIST_AW  = 16;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_LW    = $clog2(IQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_LW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_BYTE       = 3'd1,
    ST_REFUSED    = 3'd2,
    ST_END        = 3'd3,
    ST_UNWRITTEN  = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_t;

  typedef struct packed {
    act_t       kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } result_t;

endpackage

// ===== hdl/lcw_front.sv =====
// input queue that accepts and classifies incoming words
module lcw_front
  import lcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] in_byte,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_pop
);

  item_t            slots [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr;
  logic [IQ_AW-1:0] rd_ptr;
  logic [IQ_LW-1:0] level;
  logic             wr;
  logic             rd;
  item_t            incoming;

  always_comb begin
    incoming.data = in_byte;
    unique case (action)
      ACT_BYTE:  incoming.kind = ACT_BYTE;
      ACT_TICK:  incoming.kind = ACT_TICK;
      ACT_START: incoming.kind = ACT_START;
      default:   incoming.kind = ACT_NOP;
    endcase
  end

  assign full       = (level == IQ_LW'(IQ_DEPTH));
  assign item_valid = (level != '0);
  assign item       = slots[rd_ptr];
  assign wr         = push && !full;
  assign rd         = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== hdl/lcw_exec.sv =====
// command decoder, history memory and byte output stage
module lcw_exec
  import lcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  item_t            item,
  output logic             item_pop,
  input  logic [OQ_LW-1:0] out_level,
  output logic             res_valid,
  output result_t          res
);

  typedef enum logic [3:0] {
    PH_CMD    = 4'd0,
    PH_DIST   = 4'd1,
    PH_LIT    = 4'd2,
    PH_ABS_LO = 4'd3,
    PH_ABS_HI = 4'd4,
    PH_CNT_LO = 4'd5,
    PH_CNT_HI = 4'd6,
    PH_FILL_V = 4'd7,
    PH_POS_LO = 4'd8,
    PH_POS_HI = 4'd9,
    PH_RUN    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    CMD_REL   = 3'd0,
    CMD_LIT   = 3'd1,
    CMD_ABS   = 3'd2,
    CMD_FILL  = 3'd3,
    CMD_LCOPY = 3'd4
  } cmd_t;

  localparam logic [POS_W-1:0] OUT_LIMIT = POS_W'(OUT_SIZE);

  logic [7:0] hist [2**HIST_AW];

  logic [POS_W-1:0] wp, wp_next;
  phase_t           phase, phase_next;
  cmd_t             kind, kind_next;
  logic [15:0]      run, run_next;
  logic [POS_W-1:0] src, src_next;
  logic [7:0]       fill, fill_next;
  logic             finished, finished_next;

  logic             fire;
  status_t          a_status;
  logic [POS_W-1:0] a_pos;
  logic [7:0]       a_byte;
  logic             a_mem;
  logic             a_fwd;
  logic             do_emit;
  logic             tick_emit;
  logic             lit_emit;
  logic             ovf;
  logic [POS_W-1:0] rel_dist;
  logic [7:0]       c;

  logic             b_valid;
  status_t          b_status;
  logic [POS_W-1:0] b_pos;
  logic [7:0]       b_byte;
  logic             b_mem;
  logic             b_fwd;
  logic [7:0]       rdata;
  logic [7:0]       last_byte;
  logic [7:0]       b_data;
  logic             hist_wr;

  assign fire     = item_valid &&
                    ((out_level + OQ_LW'(b_valid)) < OQ_LW'(OQ_DEPTH));
  assign item_pop = fire;
  assign c        = item.data;
  assign rel_dist = src | POS_W'(c);

  always_comb begin
    wp_next       = wp;
    phase_next    = phase;
    kind_next     = kind;
    run_next      = run;
    src_next      = src;
    fill_next     = fill;
    finished_next = finished;
    a_status      = ST_NONE;
    a_byte        = '0;
    a_mem         = 1'b0;
    do_emit       = 1'b0;
    tick_emit     = 1'b0;
    lit_emit      = 1'b0;
    ovf           = 1'b0;

    priority if (item.kind == ACT_START) begin
      wp_next       = '0;
      phase_next    = PH_CMD;
      kind_next     = CMD_REL;
      run_next      = '0;
      src_next      = '0;
      fill_next     = '0;
      finished_next = 1'b0;
    end else if (item.kind == ACT_NOP) begin
      a_status = ST_NONE;
    end else if (finished) begin
      a_status = ST_END;
    end else if (item.kind == ACT_TICK) begin
      if (phase == PH_RUN) begin
        if (kind == CMD_FILL) begin
          do_emit   = 1'b1;
          tick_emit = 1'b1;
          a_byte    = fill;
        end else if (src >= wp) begin
          run_next   = '0;
          phase_next = PH_CMD;
          a_status   = ST_UNWRITTEN;
        end else begin
          do_emit   = 1'b1;
          tick_emit = 1'b1;
          a_mem     = 1'b1;
          src_next  = src + 1'b1;
        end
      end
    end else if (phase == PH_RUN) begin
      a_status = ST_REFUSED;
    end else begin
      unique case (phase)
        PH_CMD: begin
          if (!c[7]) begin
            kind_next  = CMD_REL;
            run_next   = 16'(c[6:4]) + 16'd3;
            src_next   = {5'b0, c[3:0], 8'b0};
            phase_next = PH_DIST;
          end else if (!c[6]) begin
            if (c[5:0] == 6'h00) begin
              finished_next = 1'b1;
              a_status      = ST_END;
            end else begin
              kind_next  = CMD_LIT;
              run_next   = 16'(c[5:0]);
              phase_next = PH_LIT;
            end
          end else if (c[5:0] < 6'h3e) begin
            kind_next  = CMD_ABS;
            run_next   = 16'(c[5:0]) + 16'd3;
            phase_next = PH_ABS_LO;
          end else begin
            kind_next  = (c[5:0] == 6'h3e) ? CMD_FILL : CMD_LCOPY;
            phase_next = PH_CNT_LO;
          end
        end
        PH_DIST: begin
          if (rel_dist > wp) begin
            run_next   = '0;
            phase_next = PH_CMD;
            a_status   = ST_UNWRITTEN;
          end else begin
            src_next   = wp - rel_dist;
            phase_next = (run == '0) ? PH_CMD : PH_RUN;
          end
        end
        PH_LIT: begin
          do_emit  = 1'b1;
          lit_emit = 1'b1;
          a_byte   = c;
        end
        PH_ABS_LO: begin
          src_next   = POS_W'(c);
          phase_next = PH_ABS_HI;
        end
        PH_POS_LO: begin
          src_next   = POS_W'(c);
          phase_next = PH_POS_HI;
        end
        PH_ABS_HI, PH_POS_HI: begin
          src_next   = {1'b0, c, src[7:0]};
          phase_next = (run == '0) ? PH_CMD : PH_RUN;
        end
        PH_CNT_LO: begin
          run_next   = 16'(c);
          phase_next = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          run_next   = {c, run[7:0]};
          phase_next = (kind == CMD_FILL) ? PH_FILL_V : PH_POS_LO;
        end
        PH_FILL_V: begin
          fill_next  = c;
          phase_next = (run == '0) ? PH_CMD : PH_RUN;
        end
        default: begin
          a_status = ST_REFUSED;
        end
      endcase
    end

    a_pos = wp_next;
    if (do_emit) begin
      a_pos = wp;
      if (wp >= OUT_LIMIT) begin
        ovf      = 1'b1;
        a_status = ST_OVERFLOW;
        a_byte   = '0;
        a_mem    = 1'b0;
      end else begin
        a_status = ST_BYTE;
        wp_next  = wp + 1'b1;
      end
    end
    if (tick_emit) begin
      if (ovf || run == 16'd1) begin
        run_next   = ovf ? '0 : run - 1'b1;
        phase_next = PH_CMD;
      end else begin
        run_next = run - 1'b1;
      end
    end
    if (lit_emit) begin
      run_next = run - 1'b1;
      if (run == 16'd1) begin
        phase_next = PH_CMD;
      end
    end
  end

  // previous byte is written in the same cycle as this read
  assign a_fwd   = b_valid && (b_status == ST_BYTE) &&
                   (b_pos[HIST_AW-1:0] == src[HIST_AW-1:0]);
  assign b_data  = b_mem ? (b_fwd ? last_byte : rdata) : b_byte;
  assign hist_wr = b_valid && (b_status == ST_BYTE);

  always_ff @(posedge clk) begin
    if (hist_wr) begin
      hist[b_pos[HIST_AW-1:0]] <= b_data;
    end
    if (fire && a_mem) begin
      rdata <= hist[src[HIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      phase    <= PH_CMD;
      kind     <= CMD_REL;
      run      <= '0;
      src      <= '0;
      fill     <= '0;
      finished <= 1'b0;
      b_valid  <= 1'b0;
    end else begin
      b_valid <= fire;
      if (fire) begin
        wp       <= wp_next;
        phase    <= phase_next;
        kind     <= kind_next;
        run      <= run_next;
        src      <= src_next;
        fill     <= fill_next;
        finished <= finished_next;
      end
    end
    if (fire) begin
      b_status <= a_status;
      b_pos    <= a_pos;
      b_byte   <= a_byte;
      b_mem    <= a_mem;
      b_fwd    <= a_fwd;
    end
    if (hist_wr) begin
      last_byte <= b_data;
    end
  end

  assign res_valid  = b_valid;
  assign res.status = b_status;
  assign res.data   = b_data;
  assign res.pos    = b_pos;

`ifndef NO_ASSERTIONS
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUN) |-> (run != '0))
    else $error("run pending with zero count");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= OUT_LIMIT)
    else $error("write position past buffer");

  a_byte_pos: assert property (@(posedge clk) disable iff (rst)
    (fire && a_status == ST_BYTE) |=> (wp == b_pos + 1'b1))
    else $error("emitted position out of step with write position");
`endif

endmodule

// ===== hdl/lcw_outq.sv =====
// result queue in front of the output ports
module lcw_outq
  import lcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  result_t          res,
  output logic [OQ_LW-1:0] level,
  output logic             empty,
  input  logic             pop,
  output result_t          head
);

  result_t          slots [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             rd;

  assign empty = (level == '0);
  assign head  = slots[rd_ptr];
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({res_valid, rd})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (level != OQ_LW'(OQ_DEPTH)))
    else $error("result queue overrun");
`endif

endmodule

// ===== hdl/lcw_format80_decompressor_core.sv =====
// top level of the format80 decompressor
// throughput: one word per cycle while the result queue has room, set by the single history write and read per byte
// copies read history into a register ahead of the output stage, with forwarding of the byte just written
// reset: clears all decoder state and both queues; history is not cleared
module lcw_format80_decompressor_core
  import lcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       action,
  input  logic [7:0]       in_byte,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       status,
  output logic [7:0]       out_byte,
  output logic [POS_W-1:0] out_pos
);

  logic             item_valid;
  item_t            item;
  logic             item_pop;
  logic [OQ_LW-1:0] out_level;
  logic             res_valid;
  result_t          res;
  result_t          head;

  lcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .in_byte    (in_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  lcw_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_level  (out_level),
    .res_valid  (res_valid),
    .res        (res)
  );

  lcw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .level     (out_level),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign status   = head.status;
  assign out_byte = head.data;
  assign out_pos  = head.pos;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the format80 decompressor core
`timescale 1ns / 1ps

module tb;
  import lcw_pkg::*;

  localparam int unsigned STUCK_LIMIT = 4000;

  typedef enum logic [3:0] {
    P_CMD, P_DIST, P_LIT, P_ABS_LO, P_ABS_HI, P_CNT_LO, P_CNT_HI,
    P_FILL, P_POS_LO, P_POS_HI, P_RUN
  } phase_t;

  typedef enum logic [2:0] {
    K_REL, K_LIT, K_ABS, K_FILL, K_LONG
  } cmd_kind_t;

  typedef struct {
    act_t       act;
    logic [7:0] data;
    bit         sync;
  } stream_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [1:0]       action = ACT_NOP;
  logic [7:0]       in_byte = 8'h00;
  logic             empty;
  logic             pop = 1'b0;
  logic [2:0]       status;
  logic [7:0]       out_byte;
  logic [POS_W-1:0] out_pos;

  lcw_format80_decompressor_core DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .in_byte  (in_byte),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .out_byte (out_byte),
    .out_pos  (out_pos)
  );

  always #6 clk = ~clk;

  // decoder state mirrored by the bench
  logic [7:0]       hist_mem [0:65535];
  logic [POS_W-1:0] wr_pos;
  phase_t           phase;
  cmd_kind_t        kind;
  logic [15:0]      run_left;
  logic [POS_W-1:0] src_pos;
  logic [7:0]       fill_val;
  logic             done;

  stream_word_t stream_q[$];
  result_t      decoded_q[$];
  stream_word_t cur;
  result_t      want;
  bit           sync_next = 1'b0;
  bit           held = 1'b0;
  int unsigned  n_gen = 0;
  int unsigned  words_in = 0;
  int unsigned  words_out = 0;
  int unsigned  send_gap = 0;
  int unsigned  take_gap = 0;
  int unsigned  mismatches = 0;
  int unsigned  stuck_cycles = 0;

  function automatic result_t outcome(status_t s, logic [7:0] d);
    result_t r;
    r.status = s;
    r.data = d;
    r.pos = wr_pos;
    return r;
  endfunction

  function automatic void clear_image();
    wr_pos = '0;
    phase = P_CMD;
    kind = K_REL;
    run_left = '0;
    src_pos = '0;
    fill_val = '0;
    done = 1'b0;
  endfunction

  function automatic result_t emit_byte(logic [7:0] b);
    result_t r;
    if (wr_pos >= POS_W'(OUT_SIZE)) begin
      r = outcome(ST_OVERFLOW, 8'h00);
    end else begin
      hist_mem[wr_pos[15:0]] = b;
      r = outcome(ST_BYTE, b);
      wr_pos++;
    end
    return r;
  endfunction

  function automatic void arm_run();
    phase = (run_left == 16'd0) ? P_CMD : P_RUN;
  endfunction

  function automatic result_t tick_run();
    result_t r;
    logic [7:0] b;
    r = outcome(ST_NONE, 8'h00);
    if (phase == P_RUN) begin
      if (kind != K_FILL && src_pos >= wr_pos) begin
        run_left = '0;
        phase = P_CMD;
        r = outcome(ST_UNWRITTEN, 8'h00);
      end else begin
        if (kind == K_FILL) begin
          b = fill_val;
        end else begin
          b = hist_mem[src_pos[15:0]];
          src_pos++;
        end
        r = emit_byte(b);
        if (r.status == ST_OVERFLOW) begin
          run_left = '0;
          phase = P_CMD;
        end else begin
          run_left--;
          if (run_left == 16'd0) phase = P_CMD;
        end
      end
    end
    return r;
  endfunction

  function automatic result_t take_byte(logic [7:0] c);
    result_t r;
    logic [POS_W-1:0] back;
    r = outcome(ST_NONE, 8'h00);
    case (phase)
      P_CMD: begin
        if (!c[7]) begin
          kind = K_REL;
          run_left = 16'(c[6:4]) + 16'd3;
          src_pos = {5'd0, c[3:0], 8'd0};
          phase = P_DIST;
        end else if (!c[6]) begin
          if (c[5:0] == 6'd0) begin
            done = 1'b1;
            r = outcome(ST_END, 8'h00);
          end else begin
            kind = K_LIT;
            run_left = 16'(c[5:0]);
            phase = P_LIT;
          end
        end else if (c[5:0] < 6'h3e) begin
          kind = K_ABS;
          run_left = 16'(c[5:0]) + 16'd3;
          phase = P_ABS_LO;
        end else begin
          kind = (c[5:0] == 6'h3e) ? K_FILL : K_LONG;
          phase = P_CNT_LO;
        end
      end
      P_DIST: begin
        back = src_pos | POS_W'(c);
        if (back > wr_pos) begin
          run_left = '0;
          phase = P_CMD;
          r = outcome(ST_UNWRITTEN, 8'h00);
        end else begin
          src_pos = wr_pos - back;
          arm_run();
        end
      end
      P_LIT: begin
        r = emit_byte(c);
        run_left--;
        if (run_left == 16'd0) phase = P_CMD;
      end
      P_ABS_LO: begin
        src_pos = POS_W'(c);
        phase = P_ABS_HI;
      end
      P_POS_LO: begin
        src_pos = POS_W'(c);
        phase = P_POS_HI;
      end
      P_ABS_HI, P_POS_HI: begin
        src_pos = src_pos | {1'b0, c, 8'd0};
        arm_run();
      end
      P_CNT_LO: begin
        run_left = 16'(c);
        phase = P_CNT_HI;
      end
      P_CNT_HI: begin
        run_left[15:8] = c;
        phase = (kind == K_FILL) ? P_FILL : P_POS_LO;
      end
      P_FILL: begin
        fill_val = c;
        arm_run();
      end
      default: r = outcome(ST_REFUSED, 8'h00);
    endcase
    return r;
  endfunction

  function automatic result_t decode_word(act_t a, logic [7:0] c);
    result_t r;
    if (a == ACT_START) begin
      clear_image();
      r = outcome(ST_NONE, 8'h00);
    end else if (a == ACT_NOP) begin
      r = outcome(ST_NONE, 8'h00);
    end else if (done) begin
      r = outcome(ST_END, 8'h00);
    end else if (a == ACT_TICK) begin
      r = tick_run();
    end else if (phase == P_RUN) begin
      r = outcome(ST_REFUSED, 8'h00);
    end else begin
      r = take_byte(c);
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones, and gap-free stretches
  function automatic int unsigned idle_len(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n / 128) % 5 == 4) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned run_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 17) return $urandom_range(1, 12);
    return $urandom_range(13, 400);
  endfunction

  task automatic add_word(act_t a, logic [7:0] d);
    stream_q.push_back('{act: a, data: d, sync: sync_next});
    sync_next = 1'b0;
    if (a != ACT_NOP) n_gen++;
  endtask

  task automatic add_ticks(int unsigned n);
    repeat (n) add_word(ACT_TICK, 8'($urandom));
  endtask

  // ticks for a run, with stray bytes that the core must refuse
  task automatic add_run(int unsigned n, bit junk);
    repeat (n) begin
      if (junk && $urandom_range(0, 15) == 0) add_word(ACT_BYTE, 8'($urandom));
      add_word(ACT_TICK, 8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) add_word(ACT_TICK, 8'($urandom));
  endtask

  task automatic gen_image();
    int unsigned len, sel, cnt, pos, back, mode;
    bit ok;
    len = 0;
    add_word(ACT_START, 8'($urandom));
    repeat ($urandom_range(2, 12)) begin
      sel = $urandom_range(0, 99);
      ok = ($urandom_range(0, 11) != 0);
      if (len == 0 || sel < 25) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
        add_word(ACT_BYTE, 8'h80 | 8'(cnt));
        repeat (cnt) add_word(ACT_BYTE, 8'($urandom));
        len += cnt;
      end else if (sel < 50) begin
        cnt = $urandom_range(3, 10);
        back = $urandom_range(1, (len > 4095) ? 4095 : len);
        if (!ok) back = (len < 4095 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 4095) : 0;
        add_word(ACT_BYTE, {1'b0, 3'(cnt - 3), back[11:8]});
        add_word(ACT_BYTE, back[7:0]);
        add_run(cnt, ok);
        if (ok) len += cnt;
      end else if (sel < 65) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 8);
        pos = ok ? $urandom_range(0, len - 1) : $urandom_range(len, 65535);
        add_word(ACT_BYTE, 8'hc0 | 8'(cnt - 3));
        add_word(ACT_BYTE, pos[7:0]);
        add_word(ACT_BYTE, pos[15:8]);
        add_run(cnt, ok);
        if (ok) len += cnt;
      end else if (sel < 80) begin
        cnt = run_count();
        add_word(ACT_BYTE, 8'hfe);
        add_word(ACT_BYTE, cnt[7:0]);
        add_word(ACT_BYTE, cnt[15:8]);
        add_word(ACT_BYTE, 8'($urandom));
        add_run(cnt, 1'b1);
        len += cnt;
      end else if (sel < 94) begin
        cnt = run_count();
        pos = ok ? $urandom_range(0, len - 1) : $urandom_range(len, 65535);
        add_word(ACT_BYTE, 8'hff);
        add_word(ACT_BYTE, cnt[7:0]);
        add_word(ACT_BYTE, cnt[15:8]);
        add_word(ACT_BYTE, pos[7:0]);
        add_word(ACT_BYTE, pos[15:8]);
        add_run(cnt, ok);
        if (ok) len += cnt;
      end else begin
        add_word(ACT_NOP, 8'($urandom));
        add_word(ACT_TICK, 8'($urandom));
      end
    end
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      add_word(ACT_BYTE, 8'h80);
      if (mode < 3) add_word($urandom_range(0, 1) ? ACT_TICK : ACT_BYTE, 8'($urandom));
    end else if (mode < 9) begin
      add_word(ACT_BYTE, 8'($urandom));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        decoded_q.push_back(decode_word(cur.act, cur.data));
        words_in++;
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (stream_q.size() > 0 && (!stream_q[0].sync || words_in == words_out)) begin
        cur = stream_q.pop_front();
        push <= 1'b1;
        action <= cur.act;
        in_byte <= cur.data;
        send_gap = idle_len(words_in);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: status %0d byte %02h pos %0d", status, out_byte, out_pos);
        end else begin
          want = decoded_q.pop_front();
          if (status !== want.status || out_byte !== want.data || out_pos !== want.pos) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected status %0d byte %02h pos %0d, got status %0d byte %02h pos %0d",
                       words_out, want.status, want.data, want.pos, status, out_byte, out_pos);
          end
        end
        words_out <= words_out + 1;
        take_gap = idle_len(words_out);
      end
      if (!held && words_out == 300) begin
        held = 1'b1;
        take_gap = 400;
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("lcw_format80_decompressor_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    clear_image();

    add_word(ACT_START, 8'h00);
    add_word(ACT_TICK, 8'hff);
    add_word(ACT_BYTE, 8'h83);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_BYTE, 8'h5a);
    // relative copy of ten bytes from three back, one byte refused mid-run
    add_word(ACT_BYTE, 8'h70);
    add_word(ACT_BYTE, 8'h03);
    add_word(ACT_TICK, 8'h00);
    add_word(ACT_BYTE, 8'hc3);
    add_ticks(9);
    // sources not yet written, then an absolute copy and a fill
    add_word(ACT_BYTE, 8'h7f);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_TICK, 8'h00);
    add_word(ACT_BYTE, 8'hfd);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_TICK, 8'h00);
    add_word(ACT_BYTE, 8'hc0);
    add_word(ACT_BYTE, 8'h01);
    add_word(ACT_BYTE, 8'h00);
    add_ticks(3);
    add_word(ACT_BYTE, 8'hfe);
    add_word(ACT_BYTE, 8'h02);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'ha5);
    add_ticks(2);
    // zero-count fill and long copy, then end of stream and words after it
    add_word(ACT_BYTE, 8'hfe);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h77);
    add_word(ACT_TICK, 8'h00);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_BYTE, 8'h04);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h00);
    add_ticks(4);
    add_word(ACT_BYTE, 8'hff);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h00);
    add_word(ACT_BYTE, 8'h12);
    add_word(ACT_BYTE, 8'h34);
    add_word(ACT_NOP, 8'hff);
    add_word(ACT_BYTE, 8'h80);
    add_word(ACT_BYTE, 8'h55);
    add_word(ACT_TICK, 8'h00);
    add_word(ACT_NOP, 8'h00);

    sync_next = 1'b1;
    base = n_gen;
    while (n_gen < base + 950) gen_image();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stream_q.size() != 0 || push || words_out != words_in);
    repeat (8) @(negedge clk);

    if (decoded_q.size() != 0) $display("%0d expected words never arrived", decoded_q.size());
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("lcw_format80_decompressor_core regression: pass");
    end else begin
      $display("lcw_format80_decompressor_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== lcw_format80_decompressor_core.f =====
hdl/lcw_pkg.sv
hdl/lcw_front.sv
hdl/lcw_exec.sv
hdl/lcw_outq.sv
hdl/lcw_format80_decompressor_core.sv
bench/tb.sv
